// ===== hdl/ntdm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntdm_pkg
// Shared types and constants of the NTC thermal derate monitor.
// ----------------------------------------------------------------------------
package ntdm_pkg;

  localparam int unsigned SAMPLES_DEF     = 16;
  localparam int unsigned NOMINAL_CENTI_K = 29815;
  localparam int unsigned SMP_W           = 12;
  localparam int unsigned Q_DEPTH         = 2;

  // shared divider geometry
  localparam int unsigned DIVD_W = 64;
  localparam int unsigned DIVS_W = 48;
  localparam int unsigned DCNT_W = 7;

  localparam logic [16:0]        FULL_Q16   = 17'd65536;
  localparam logic signed [15:0] TEMP_MIN   = -16'sd5000;
  localparam logic signed [15:0] TEMP_MAX   = 16'sd20000;
  localparam logic signed [15:0] TEMP_RST   = 16'sd2500;
  localparam logic [16:0]        ZERO_C_CK  = 17'd27315;
  localparam logic [63:0]        TK_LO      = 64'd22315;
  localparam logic [63:0]        TK_HI      = 64'd47315;
  localparam logic [29:0]        LN2_Q30    = 30'd744261118;
  localparam logic [15:0]        NCK        = 16'(NOMINAL_CENTI_K);
  localparam logic [21:0]        NUM_K      = 22'(100 * NOMINAL_CENTI_K);
  localparam logic [6:0]         HUNDRED    = 7'd100;

  typedef enum logic [2:0] {
    REG_VIN_RATIO = 3'd0,
    REG_RAIL      = 3'd1,
    REG_SERIES    = 3'd2,
    REG_NOMINAL   = 3'd3,
    REG_BETA      = 3'd4,
    REG_DR_START  = 3'd5,
    REG_DR_FULL   = 3'd6,
    REG_RECOVER   = 3'd7
  } reg_idx_t;

  localparam logic [15:0]        RST_VIN_RATIO = 16'd2816;
  localparam logic [12:0]        RST_RAIL      = 13'd3300;
  localparam logic [19:0]        RST_SERIES    = 20'd10000;
  localparam logic [19:0]        RST_NOMINAL   = 20'd10000;
  localparam logic [13:0]        RST_BETA      = 14'd3950;
  localparam logic signed [15:0] RST_DR_START  = 16'sd7000;
  localparam logic signed [15:0] RST_DR_FULL   = 16'sd8500;
  localparam logic signed [15:0] RST_RECOVER   = 16'sd6500;

  typedef struct packed {
    logic [15:0]        vin_ratio_q8;
    logic [12:0]        rail_mv;
    logic [19:0]        series_ohms;
    logic [19:0]        nominal_ohms;
    logic [13:0]        beta_k;
    logic signed [15:0] derate_start;
    logic signed [15:0] derate_full;
    logic signed [15:0] recover_temp;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [63:0]       dividend;
    logic [47:0]       divisor;
    logic [6:0]        nbits;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [63:0]       quotient;
  } div_rsp_t;

endpackage

// ===== hdl/ntdm_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntdm_fifo
// Short queue of finished sample groups between front end and back end.
// ----------------------------------------------------------------------------
module ntdm_fifo #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         vld,
  output logic         full
);

  localparam int unsigned PTR_W = (ntdm_pkg::Q_DEPTH > 1) ? $clog2(ntdm_pkg::Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(ntdm_pkg::Q_DEPTH + 1);

  logic [W-1:0]     mem_r [ntdm_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign vld      = (cnt_r != '0);
  assign full     = (cnt_r == CNT_W'(ntdm_pkg::Q_DEPTH));
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(ntdm_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(ntdm_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst_n) begin
      a_no_overflow: assert property (full |-> !push || pop)
        else $error("ntdm_fifo: push into full queue");
      a_no_underflow: assert property (pop |-> vld)
        else $error("ntdm_fifo: pop from empty queue");
    end
  end

endmodule

// ===== hdl/ntdm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntdm_front
// Accepts sample beats, accumulates both channels and queues each group sum.
// ----------------------------------------------------------------------------
module ntdm_front #(
  parameter int unsigned SAMPLES = ntdm_pkg::SAMPLES_DEF,
  parameter int unsigned SUM_W   = ntdm_pkg::SMP_W + $clog2(SAMPLES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [23:0]        in_tdata,
  input  logic               q_full,
  output logic               q_push,
  output logic [2*SUM_W-1:0] q_data
);

  localparam int unsigned CNT_W = $clog2(SAMPLES);

  logic [SUM_W-1:0] sup_sum_r;
  logic [SUM_W-1:0] sen_sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] sup_nxt;
  logic [SUM_W-1:0] sen_nxt;
  logic             is_last;
  logic             accept;

  assign is_last   = (cnt_r == CNT_W'(SAMPLES - 1));
  assign in_tready = !is_last || !q_full;
  assign accept    = in_tvalid && in_tready;
  assign sup_nxt   = sup_sum_r + SUM_W'(in_tdata[11:0]);
  assign sen_nxt   = sen_sum_r + SUM_W'(in_tdata[23:12]);
  assign q_push    = accept && is_last;
  assign q_data    = {sen_nxt, sup_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_sum_r <= '0;
      sen_sum_r <= '0;
      cnt_r     <= '0;
    end else if (accept) begin
      if (is_last) begin
        sup_sum_r <= '0;
        sen_sum_r <= '0;
        cnt_r     <= '0;
      end else begin
        sup_sum_r <= sup_nxt;
        sen_sum_r <= sen_nxt;
        cnt_r     <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst_n) begin
      a_push_on_last: assert property (q_push |-> is_last && !q_full)
        else $error("ntdm_front: group pushed off its last beat");
      a_cnt_range: assert property (cnt_r <= CNT_W'(SAMPLES - 1))
        else $error("ntdm_front: sample counter out of range");
      a_clear_after_push: assert property (q_push |=> (cnt_r == '0 && sup_sum_r == '0))
        else $error("ntdm_front: sums not cleared after group");
    end
  end

endmodule

// ===== hdl/ntdm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntdm_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntdm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ntdm_pkg::div_req_t req,
  output ntdm_pkg::div_rsp_t rsp
);

  logic [ntdm_pkg::DIVD_W-1:0] quo_r;
  logic [ntdm_pkg::DIVS_W-1:0] rem_r;
  logic [ntdm_pkg::DIVS_W-1:0] dvs_r;
  logic [ntdm_pkg::DCNT_W-1:0] cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [ntdm_pkg::DIVS_W:0]   rem_sh;
  logic                        ge;
  logic [ntdm_pkg::DIVS_W:0]   rem_sub;

  assign rem_sh  = {rem_r, quo_r[ntdm_pkg::DIVD_W-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  assign rsp.done     = done_r;
  assign rsp.busy     = busy_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[ntdm_pkg::DIVD_W-2:0], ge};
      rem_r <= ge ? rem_sub[ntdm_pkg::DIVS_W-1:0] : rem_sh[ntdm_pkg::DIVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ntdm_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst_n) begin
      a_cnt_live: assert property (busy_r |-> cnt_r != '0)
        else $error("ntdm_div: busy with zero count");
      a_done_after_busy: assert property (done_r |-> $past(busy_r) && !busy_r)
        else $error("ntdm_div: done without a finished run");
      a_start_idle: assert property (req.start |-> !busy_r)
        else $error("ntdm_div: start while busy");
    end
  end

endmodule

// ===== hdl/ntdm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntdm_back
// Averages one group, converts it to supply, temperature and derate, and
// holds the result beat in the output register.
// ----------------------------------------------------------------------------
module ntdm_back #(
  parameter int unsigned SAMPLES = ntdm_pkg::SAMPLES_DEF,
  parameter int unsigned SUM_W   = ntdm_pkg::SMP_W + $clog2(SAMPLES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ntdm_pkg::cfg_t     cfg,
  input  logic               q_vld,
  input  logic [2*SUM_W-1:0] q_data,
  output logic               q_pop,
  output ntdm_pkg::div_req_t div_req,
  input  ntdm_pkg::div_rsp_t div_rsp,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [55:0]        out_tdata
);

  // average by reciprocal multiply, exact floor for any sum below 2^16
  localparam int unsigned      AVG_K     = 21;
  localparam int unsigned      AVG_W     = SUM_W + AVG_K;
  localparam logic [AVG_K-1:0] AVG_RECIP = AVG_K'(((1 << AVG_K) + SAMPLES - 1) / SAMPLES);

  typedef enum logic [20:0] {
    S_IDLE     = 21'h000001,
    S_AVG_SUP  = 21'h000002,
    S_AVG_SEN  = 21'h000004,
    S_SUPPLY   = 21'h000008,
    S_CHECK    = 21'h000010,
    S_LOG_MUL  = 21'h000020,
    S_LOG_NORM = 21'h000040,
    S_LOG_ITER = 21'h000080,
    S_MAG      = 21'h000100,
    S_LN_LO    = 21'h000200,
    S_LN_HI    = 21'h000400,
    S_LN_SUM   = 21'h000800,
    S_ADJ      = 21'h001000,
    S_DEN      = 21'h002000,
    S_DCHK     = 21'h004000,
    S_TK_DIV   = 21'h008000,
    S_SAT      = 21'h010000,
    S_DR       = 21'h020000,
    S_DR_DIV   = 21'h040000,
    S_LATCH    = 21'h080000,
    S_OUT      = 21'h100000
  } state_t;

  state_t             state_r;
  logic [SUM_W-1:0]   sup_sum_r;
  logic [SUM_W-1:0]   sen_sum_r;
  logic [11:0]        sup_avg_r;
  logic [11:0]        sen_avg_r;
  logic [19:0]        supply_r;
  logic               fault_r;
  logic signed [15:0] temp_r;
  logic signed [15:0] last_temp_r;
  logic               ot_r;
  logic               sel_r;
  logic [32:0]        x_r;
  logic [5:0]         sh_cnt_r;
  logic [5:0]         p_r;
  logic [30:0]        lm_r;
  logic [27:0]        frac_r;
  logic [4:0]         it_r;
  logic [33:0]        la_r;
  logic [33:0]        lb_r;
  logic [33:0]        mag_r;
  logic               neg_r;
  logic [46:0]        plo_r;
  logic [46:0]        phi_r;
  logic [29:0]        lnq_r;
  logic [45:0]        adj_r;
  logic [47:0]        base_r;
  logic signed [47:0] den_r;
  logic [35:0]        num_r;
  logic [16:0]        derate_r;
  logic               out_vld_r;
  logic [19:0]        o_supply_r;
  logic signed [15:0] o_temp_r;
  logic [16:0]        o_derate_r;
  logic               o_ot_r;
  logic               o_fault_r;

  logic [19:0]        ser_eff;
  logic [19:0]        nom_eff;
  logic [13:0]        beta_eff;
  logic [12:0]        rail_less_m;
  logic [19:0]        mul_a;
  logic [12:0]        mul_b;
  logic [61:0]        sq;
  logic [31:0]        sq_top;
  logic [63:0]        ln_sum;
  logic               fault;
  logic signed [16:0] full_less_t;
  logic signed [16:0] full_less_start;
  logic [63:0]        tk;
  logic               ot_nxt;
  logic [SUM_W-1:0]   q_sup;
  logic [SUM_W-1:0]   q_sen;
  logic [SUM_W-1:0]   avg_src;
  logic [AVG_W-1:0]   avg_prod;

  assign ser_eff     = (cfg.series_ohms == '0) ? 20'd1 : cfg.series_ohms;
  assign nom_eff     = (cfg.nominal_ohms == '0) ? 20'd1 : cfg.nominal_ohms;
  assign beta_eff    = (cfg.beta_k == '0) ? 14'd1 : cfg.beta_k;
  assign rail_less_m = cfg.rail_mv - {1'b0, sen_avg_r};
  assign mul_a       = sel_r ? nom_eff : ser_eff;
  assign mul_b       = sel_r ? rail_less_m : {1'b0, sen_avg_r};
  assign sq          = 62'(lm_r) * 62'(lm_r);
  assign sq_top      = sq[61:30];
  assign ln_sum      = {phi_r, 17'b0} + 64'(plo_r);
  assign fault       = (sen_avg_r <= 12'd1) ||
                       (({1'b0, sen_avg_r} + 13'd1) >= cfg.rail_mv);
  assign full_less_t     = {cfg.derate_full[15], cfg.derate_full} - {temp_r[15], temp_r};
  assign full_less_start = {cfg.derate_full[15], cfg.derate_full} -
                           {cfg.derate_start[15], cfg.derate_start};
  assign tk          = div_rsp.quotient;
  assign q_sup       = q_data[SUM_W-1:0];
  assign q_sen       = q_data[2*SUM_W-1:SUM_W];
  assign q_pop       = (state_r == S_IDLE) && q_vld;
  assign avg_src     = (state_r == S_AVG_SEN) ? sen_sum_r : sup_sum_r;
  assign avg_prod    = AVG_W'(avg_src) * AVG_W'(AVG_RECIP);

  always_comb begin
    ot_nxt = ot_r;
    if (ot_r && (temp_r < cfg.recover_temp)) begin
      ot_nxt = 1'b0;
    end
    if (derate_r != ntdm_pkg::FULL_Q16) begin
      ot_nxt = 1'b1;
    end
  end

  always_comb begin
    div_req       = '0;
    if (state_r == S_DCHK && !den_r[47] && den_r != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = (64'(num_r) << 24) + 64'(den_r[47:1]);
      div_req.divisor  = den_r;
      div_req.nbits    = ntdm_pkg::DCNT_W'(ntdm_pkg::DIVD_W);
    end else if (state_r == S_DR && (temp_r < cfg.derate_full) &&
                 (temp_r > cfg.derate_start)) begin
      div_req.start    = 1'b1;
      div_req.dividend = {full_less_t, 47'b0};
      div_req.divisor  = ntdm_pkg::DIVS_W'(full_less_start);
      div_req.nbits    = ntdm_pkg::DCNT_W'(33);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_temp_r <= ntdm_pkg::TEMP_RST;
      ot_r        <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (out_vld_r && out_tready && (state_r != S_OUT)) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_vld) begin
            sup_sum_r <= q_sup;
            sen_sum_r <= q_sen;
            state_r   <= S_AVG_SUP;
          end
        end
        S_AVG_SUP: begin
          sup_avg_r <= avg_prod[AVG_K +: 12];
          state_r   <= S_AVG_SEN;
        end
        S_AVG_SEN: begin
          sen_avg_r <= avg_prod[AVG_K +: 12];
          state_r   <= S_SUPPLY;
        end
        S_SUPPLY: begin
          supply_r <= 20'((28'(sup_avg_r) * 28'(cfg.vin_ratio_q8)) >> 8);
          state_r  <= S_CHECK;
        end
        S_CHECK: begin
          fault_r <= fault;
          sel_r   <= 1'b0;
          if (fault) begin
            temp_r  <= last_temp_r;
            state_r <= S_DR;
          end else begin
            state_r <= S_LOG_MUL;
          end
        end
        S_LOG_MUL: begin
          x_r      <= 33'(mul_a) * 33'(mul_b);
          sh_cnt_r <= '0;
          state_r  <= S_LOG_NORM;
        end
        S_LOG_NORM: begin
          // shift left until the leading one reaches the top bit
          if (x_r[32]) begin
            lm_r    <= x_r[32:2];
            p_r     <= 6'd32 - sh_cnt_r;
            it_r    <= '0;
            state_r <= S_LOG_ITER;
          end else begin
            x_r      <= {x_r[31:0], 1'b0};
            sh_cnt_r <= sh_cnt_r + 1'b1;
          end
        end
        S_LOG_ITER: begin
          frac_r <= {frac_r[26:0], sq_top[31]};
          lm_r   <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
          it_r   <= it_r + 1'b1;
          if (it_r == 5'd27) begin
            if (!sel_r) begin
              la_r    <= {p_r, frac_r[26:0], sq_top[31]};
              sel_r   <= 1'b1;
              state_r <= S_LOG_MUL;
            end else begin
              lb_r    <= {p_r, frac_r[26:0], sq_top[31]};
              state_r <= S_MAG;
            end
          end
        end
        S_MAG: begin
          neg_r   <= (la_r < lb_r);
          mag_r   <= (la_r < lb_r) ? (lb_r - la_r) : (la_r - lb_r);
          state_r <= S_LN_LO;
        end
        S_LN_LO: begin
          plo_r   <= 47'(mag_r[16:0]) * 47'(ntdm_pkg::LN2_Q30);
          state_r <= S_LN_HI;
        end
        S_LN_HI: begin
          phi_r   <= 47'(mag_r[33:17]) * 47'(ntdm_pkg::LN2_Q30);
          state_r <= S_LN_SUM;
        end
        S_LN_SUM: begin
          lnq_r   <= ln_sum[63:34];
          state_r <= S_ADJ;
        end
        S_ADJ: begin
          adj_r   <= 46'(ntdm_pkg::NCK) * 46'(lnq_r);
          base_r  <= (48'(beta_eff) * 48'(ntdm_pkg::HUNDRED)) << 24;
          state_r <= S_DEN;
        end
        S_DEN: begin
          den_r   <= neg_r ? $signed(base_r - 48'(adj_r)) : $signed(base_r + 48'(adj_r));
          num_r   <= 36'(beta_eff) * 36'(ntdm_pkg::NUM_K);
          state_r <= S_DCHK;
        end
        S_DCHK: begin
          if (den_r[47]) begin
            temp_r      <= ntdm_pkg::TEMP_MIN;
            last_temp_r <= ntdm_pkg::TEMP_MIN;
            state_r     <= S_DR;
          end else if (den_r == '0) begin
            temp_r      <= ntdm_pkg::TEMP_MAX;
            last_temp_r <= ntdm_pkg::TEMP_MAX;
            state_r     <= S_DR;
          end else begin
            state_r <= S_TK_DIV;
          end
        end
        S_TK_DIV: begin
          if (div_rsp.done) begin
            state_r <= S_SAT;
          end
        end
        S_SAT: begin
          priority if (tk < ntdm_pkg::TK_LO) begin
            temp_r      <= ntdm_pkg::TEMP_MIN;
            last_temp_r <= ntdm_pkg::TEMP_MIN;
          end else if (tk > ntdm_pkg::TK_HI) begin
            temp_r      <= ntdm_pkg::TEMP_MAX;
            last_temp_r <= ntdm_pkg::TEMP_MAX;
          end else begin
            temp_r      <= 16'({1'b0, tk[15:0]} - ntdm_pkg::ZERO_C_CK);
            last_temp_r <= 16'({1'b0, tk[15:0]} - ntdm_pkg::ZERO_C_CK);
          end
          state_r <= S_DR;
        end
        S_DR: begin
          priority if (temp_r >= cfg.derate_full) begin
            derate_r <= '0;
            state_r  <= S_LATCH;
          end else if (temp_r > cfg.derate_start) begin
            state_r <= S_DR_DIV;
          end else begin
            derate_r <= ntdm_pkg::FULL_Q16;
            state_r  <= S_LATCH;
          end
        end
        S_DR_DIV: begin
          if (div_rsp.done) begin
            derate_r <= tk[16:0];
            state_r  <= S_LATCH;
          end
        end
        S_LATCH: begin
          ot_r    <= ot_nxt;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // wait for the output register to free up
          if (!out_vld_r || out_tready) begin
            out_vld_r  <= 1'b1;
            o_supply_r <= supply_r;
            o_temp_r   <= temp_r;
            o_derate_r <= derate_r;
            o_ot_r     <= ot_r;
            o_fault_r  <= fault_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, o_fault_r, o_ot_r, o_derate_r, o_temp_r, o_supply_r};

  always_ff @(posedge clk) begin
    if (rst_n) begin
      a_derate_max: assert property (out_vld_r |-> o_derate_r <= ntdm_pkg::FULL_Q16)
        else $error("ntdm_back: derate above full scale");
      a_temp_range: assert property (out_vld_r |->
          (o_temp_r >= ntdm_pkg::TEMP_MIN && o_temp_r <= ntdm_pkg::TEMP_MAX))
        else $error("ntdm_back: temperature outside saturation range");
      a_latch_set: assert property ((out_vld_r && o_derate_r != ntdm_pkg::FULL_Q16) |-> o_ot_r)
        else $error("ntdm_back: derating without over-temperature flag");
      a_den_pos: assert property ((state_r == S_TK_DIV) |-> (!den_r[47] && den_r != '0))
        else $error("ntdm_back: divide by nonpositive denominator");
    end
  end

endmodule

// ===== hdl/ntc_thermal_derate_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_thermal_derate_monitor
// Averages supply and NTC thermistor samples and reports a derate factor.
// ----------------------------------------------------------------------------
// Input stream: one beat per ADC sample pair. After every SAMPLES_PER_AVERAGE
// beats one result beat leaves on the output stream with the scaled supply,
// the temperature in centi-degrees C, the Q16 derate factor, the latched
// over-temperature flag and the sensor fault flag.
// The front end takes one beat per cycle unless a group ends while the queue
// is full; a two-entry group queue sits between it and the back end. The
// back end computes per group the averages (reciprocal multiply), the two
// logarithms with up to 31 normalize shifts each, the temperature divide and
// the derate divide, paced by the shared one-bit-per-cycle divider and the
// one-square-per-cycle log unit. The front end keeps taking beats of later
// groups while the back end works on one, with up to two groups queued.
// A faulty sensor skips the logarithm and temperature divide.
// Reset clears sums, queue, latch and output, loads the register defaults and
// sets the held temperature to 25.00 C. A stalled output holds its beat;
// the back end and then the queue fill and in_tready drops on a group end.
// Configuration is to be written over the APB port only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ntc_thermal_derate_monitor #(
  parameter int unsigned SAMPLES_PER_AVERAGE = ntdm_pkg::SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [11:0] supply_sample_mv, [23:12] sensor_sample_mv
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [19:0] supply_mv, [35:20] temp_centi_c,
                                   // [52:36] derate_q16, [53] over_temp,
                                   // [54] sensor_fault, [55] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned SUM_W = ntdm_pkg::SMP_W + $clog2(SAMPLES_PER_AVERAGE);

  ntdm_pkg::cfg_t     cfg_r;
  ntdm_pkg::reg_idx_t widx;
  ntdm_pkg::div_req_t div_req;
  ntdm_pkg::div_rsp_t div_rsp;
  logic               wr_en;
  logic               q_push;
  logic               q_pop;
  logic               q_vld;
  logic               q_full;
  logic [2*SUM_W-1:0] q_wdata;
  logic [2*SUM_W-1:0] q_rdata;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign widx       = ntdm_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vin_ratio_q8 <= ntdm_pkg::RST_VIN_RATIO;
      cfg_r.rail_mv      <= ntdm_pkg::RST_RAIL;
      cfg_r.series_ohms  <= ntdm_pkg::RST_SERIES;
      cfg_r.nominal_ohms <= ntdm_pkg::RST_NOMINAL;
      cfg_r.beta_k       <= ntdm_pkg::RST_BETA;
      cfg_r.derate_start <= ntdm_pkg::RST_DR_START;
      cfg_r.derate_full  <= ntdm_pkg::RST_DR_FULL;
      cfg_r.recover_temp <= ntdm_pkg::RST_RECOVER;
    end else if (wr_en) begin
      unique case (widx)
        ntdm_pkg::REG_VIN_RATIO: cfg_r.vin_ratio_q8 <= cfg_pwdata[15:0];
        ntdm_pkg::REG_RAIL:      cfg_r.rail_mv      <= cfg_pwdata[12:0];
        ntdm_pkg::REG_SERIES:    cfg_r.series_ohms  <= cfg_pwdata[19:0];
        ntdm_pkg::REG_NOMINAL:   cfg_r.nominal_ohms <= cfg_pwdata[19:0];
        ntdm_pkg::REG_BETA:      cfg_r.beta_k       <= cfg_pwdata[13:0];
        ntdm_pkg::REG_DR_START:  cfg_r.derate_start <= $signed(cfg_pwdata[15:0]);
        ntdm_pkg::REG_DR_FULL:   cfg_r.derate_full  <= $signed(cfg_pwdata[15:0]);
        ntdm_pkg::REG_RECOVER:   cfg_r.recover_temp <= $signed(cfg_pwdata[15:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      ntdm_pkg::REG_VIN_RATIO: cfg_prdata = 32'(cfg_r.vin_ratio_q8);
      ntdm_pkg::REG_RAIL:      cfg_prdata = 32'(cfg_r.rail_mv);
      ntdm_pkg::REG_SERIES:    cfg_prdata = 32'(cfg_r.series_ohms);
      ntdm_pkg::REG_NOMINAL:   cfg_prdata = 32'(cfg_r.nominal_ohms);
      ntdm_pkg::REG_BETA:      cfg_prdata = 32'(cfg_r.beta_k);
      ntdm_pkg::REG_DR_START:  cfg_prdata = 32'(signed'(cfg_r.derate_start));
      ntdm_pkg::REG_DR_FULL:   cfg_prdata = 32'(signed'(cfg_r.derate_full));
      ntdm_pkg::REG_RECOVER:   cfg_prdata = 32'(signed'(cfg_r.recover_temp));
      default:                 cfg_prdata = '0;
    endcase
  end

  ntdm_front #(
    .SAMPLES (SAMPLES_PER_AVERAGE),
    .SUM_W   (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  ntdm_fifo #(
    .W (2 * SUM_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .vld       (q_vld),
    .full      (q_full)
  );

  ntdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ntdm_back #(
    .SAMPLES (SAMPLES_PER_AVERAGE),
    .SUM_W   (SUM_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_vld      (q_vld),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/sv/tb_ntc_thermal_derate_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ntc_thermal_derate_monitor
// Self-checking bench for the NTC thermal derate monitor.
// ----------------------------------------------------------------------------
// Sample pairs are streamed in whole groups under several register settings.
// A directed table comes first, then random groups, four in ten of them centered
// near the derating band. A local predictor computes averages, the beta-equation
// temperature, derate and latch; every result beat is compared field by field.
// Both stream sides idle at random, and one phase stalls the output for a long
// stretch while input keeps coming.
// ----------------------------------------------------------------------------
module tb_ntc_thermal_derate_monitor;

  localparam int GROUP     = 16;
  localparam int HOLD_CYC  = 3000;
  localparam int SETTLE    = 300;

  typedef struct packed {
    logic [19:0]        supply_mv;
    logic signed [15:0] temp_centi_c;
    logic [16:0]        derate_q16;
    logic               over_temp;
    logic               sensor_fault;
  } result_t;

  typedef struct {
    logic [11:0] supply;
    logic [11:0] sensor;
    bit          typed;
    result_t     want;
  } dir_row_t;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [23:0] in_tdata;    // [11:0] supply_sample_mv, [23:12] sensor_sample_mv
  logic        out_tvalid, out_tready;
  logic [55:0] out_tdata;   // [19:0] supply_mv, [35:20] temp_centi_c,
                            // [52:36] derate_q16, [53] over_temp, [54] sensor_fault
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  ntc_thermal_derate_monitor dut (.*);

  // predictor copy of registers and state
  ntdm_pkg::cfg_t     regs;
  logic [15:0]        supply_acc, sensor_acc;
  int                 beats_in_group;
  logic signed [15:0] held_temp;
  logic               ot_latch;

  result_t expected_q[$];
  int      n_err, n_results, n_faults, n_hot, n_beats;
  bit      no_gaps, hold_req;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("tb_ntc_thermal_derate_monitor NOT OK");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint unsigned log2_q28(longint unsigned x);
    int p;
    longint unsigned m, r;
    if (x == 0) x = 1;
    p = 0;
    while (p < 63 && (x >> (p + 1)) != 0) p++;
    m = (p <= 30) ? (x << (30 - p)) : (x >> (p - 30));
    r = longint'(p) << 28;
    for (int i = 27; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        r |= 64'd1 << i;
      end
    end
    return r;
  endfunction

  function automatic logic signed [15:0] beta_temp(longint unsigned m);
    longint unsigned ser, nom, la, lb, mag;
    longint          beta, lnq, base, adj, den, tk, t;
    bit              neg;
    ser  = (regs.series_ohms == 0) ? 1 : regs.series_ohms;
    nom  = (regs.nominal_ohms == 0) ? 1 : regs.nominal_ohms;
    beta = (regs.beta_k == 0) ? 1 : regs.beta_k;
    la   = log2_q28(ser * m);
    lb   = log2_q28(nom * (longint'(regs.rail_mv) - m));
    neg  = la < lb;
    mag  = neg ? lb - la : la - lb;
    lnq  = longint'((mag * 64'(ntdm_pkg::LN2_Q30)) >> 34);
    base = beta * 100 * (longint'(1) << 24);
    adj  = longint'(ntdm_pkg::NOMINAL_CENTI_K) * lnq;
    den  = neg ? base - adj : base + adj;
    if (den < 0) return ntdm_pkg::TEMP_MIN;
    if (den == 0) return ntdm_pkg::TEMP_MAX;
    tk = (longint'(ntdm_pkg::NOMINAL_CENTI_K) * base + den / 2) / den;
    t  = tk - longint'(ntdm_pkg::ZERO_C_CK);
    if (t < ntdm_pkg::TEMP_MIN) t = ntdm_pkg::TEMP_MIN;
    if (t > ntdm_pkg::TEMP_MAX) t = ntdm_pkg::TEMP_MAX;
    return 16'(t);
  endfunction

  // accumulate one beat; returns 1 with the group result on a group end
  function automatic bit monitor_step(logic [11:0] sup, logic [11:0] sen,
                                      output result_t res);
    int     sup_avg, sen_avg, t, s, f;
    longint der;
    bit     fault;
    supply_acc = supply_acc + sup;
    sensor_acc = sensor_acc + sen;
    if (beats_in_group + 1 < GROUP) begin
      beats_in_group++;
      return 0;
    end
    sup_avg = supply_acc / GROUP;
    sen_avg = sensor_acc / GROUP;
    supply_acc = 0;
    sensor_acc = 0;
    beats_in_group = 0;
    fault = (sen_avg <= 1) || (sen_avg + 1 >= int'(regs.rail_mv));
    if (!fault) held_temp = beta_temp(sen_avg);
    t = held_temp;
    s = regs.derate_start;
    f = regs.derate_full;
    if (t >= f) der = 0;
    else if (t > s) der = (longint'(f - t) * 65536) / longint'(f - s);
    else der = 65536;
    if (ot_latch && t < int'(regs.recover_temp)) ot_latch = 0;
    if (der < 65536) ot_latch = 1;
    res.supply_mv    = 20'((longint'(sup_avg) * regs.vin_ratio_q8) >> 8);
    res.temp_centi_c = held_temp;
    res.derate_q16   = 17'(der);
    res.over_temp    = ot_latch;
    res.sensor_fault = fault;
    return 1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    n_err++;
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.supply_mv    = out_tdata[19:0];
      got.temp_centi_c = out_tdata[35:20];
      got.derate_q16   = out_tdata[52:36];
      got.over_temp    = out_tdata[53];
      got.sensor_fault = out_tdata[54];
      n_results++;
      if (got.sensor_fault) n_faults++;
      if (got.over_temp) n_hot++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat, supply", got.supply_mv, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.supply_mv != want.supply_mv)
          report_mismatch("supply_mv", got.supply_mv, want.supply_mv);
        if (got.temp_centi_c != want.temp_centi_c)
          report_mismatch("temp_centi_c", got.temp_centi_c, want.temp_centi_c);
        if (got.derate_q16 != want.derate_q16)
          report_mismatch("derate_q16", got.derate_q16, want.derate_q16);
        if (got.over_temp != want.over_temp)
          report_mismatch("over_temp", got.over_temp, want.over_temp);
        if (got.sensor_fault != want.sensor_fault)
          report_mismatch("sensor_fault", got.sensor_fault, want.sensor_fault);
      end
    end
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int g;
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 0;
        for (int c = 0; c < HOLD_CYC; c++) @(negedge clk);
        hold_req = 0;
      end
      g = gap_len();
      if (g > 0) begin
        out_tready = 0;
        repeat (g) @(negedge clk);
      end
      out_tready = 1;
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_beat(logic [11:0] sup, logic [11:0] sen, bit typed, result_t want);
    result_t res;
    int      g;
    in_tdata  = {sen, sup};
    in_tvalid = 1;
    do @(posedge clk); while (!in_tready);
    n_beats++;
    if (monitor_step(sup, sen, res)) expected_q.push_back(typed ? want : res);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_tvalid = 0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic write_reg(ntdm_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_psel    = 1;
    cfg_pwrite  = 1;
    cfg_penable = 0;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1;
    @(negedge clk);
    cfg_psel    = 0;
    cfg_penable = 0;
    cfg_pwrite  = 0;
    case (idx)
      ntdm_pkg::REG_VIN_RATIO: regs.vin_ratio_q8 = val[15:0];
      ntdm_pkg::REG_RAIL:      regs.rail_mv      = val[12:0];
      ntdm_pkg::REG_SERIES:    regs.series_ohms  = val[19:0];
      ntdm_pkg::REG_NOMINAL:   regs.nominal_ohms = val[19:0];
      ntdm_pkg::REG_BETA:      regs.beta_k       = val[13:0];
      ntdm_pkg::REG_DR_START:  regs.derate_start = val[15:0];
      ntdm_pkg::REG_DR_FULL:   regs.derate_full  = val[15:0];
      ntdm_pkg::REG_RECOVER:   regs.recover_temp = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(logic [31:0] v[8]);
    for (int i = 0; i < 8; i++) write_reg(ntdm_pkg::reg_idx_t'(i), v[i]);
  endtask

  // lower valid, wait for all results and for any group still in flight
  task automatic drain();
    in_tvalid = 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic random_groups(int n_groups);
    result_t none;
    int      mode, c, rail, v;
    logic [11:0] sup;
    none = '0;
    for (int gi = 0; gi < n_groups; gi++) begin
      mode = $urandom_range(0, 9);
      rail = regs.rail_mv;
      if (rail > 4095) rail = 4095;
      if (mode < 4) c = rail * $urandom_range(60, 240) / 1000;
      else c = $urandom_range(0, (rail > 4) ? rail - 2 : 4);
      sup = $urandom_range(0, 4095);
      for (int b = 0; b < GROUP; b++) begin
        case (mode)
          7: v = $urandom_range(0, 4095);
          8: v = $urandom_range(0, 3);
          9: v = $urandom_range(rail > 3 ? rail - 3 : 0, 4095);
          default: v = c + $urandom_range(0, 16) - 8;
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        if ($urandom_range(0, 3) == 0) sup = $urandom_range(0, 4095);
        send_beat(sup, 12'(v), 0, none);
      end
    end
  endtask

  dir_row_t dir_rows[10];

  initial begin
    logic [31:0] s[8];
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    no_gaps = 0;
    hold_req = 0;
    n_err = 0;
    n_results = 0;
    n_faults = 0;
    n_hot = 0;
    n_beats = 0;
    regs = '{ntdm_pkg::RST_VIN_RATIO, ntdm_pkg::RST_RAIL, ntdm_pkg::RST_SERIES,
             ntdm_pkg::RST_NOMINAL, ntdm_pkg::RST_BETA, ntdm_pkg::RST_DR_START,
             ntdm_pkg::RST_DR_FULL, ntdm_pkg::RST_RECOVER};
    supply_acc = 0;
    sensor_acc = 0;
    beats_in_group = 0;
    held_temp = ntdm_pkg::TEMP_RST;
    ot_latch = 0;

    // each row is one whole group of identical beats at reset settings
    dir_rows = '{
      '{12'd4095, 12'd0,    1, '{20'd45045, 16'sd2500, 17'd65536, 1'b0, 1'b1}},
      '{12'd0,    12'd4095, 1, '{20'd0,     16'sd2500, 17'd65536, 1'b0, 1'b1}},
      '{12'd1000, 12'd1650, 1, '{20'd11000, 16'sd2500, 17'd65536, 1'b0, 1'b0}},
      '{12'd12,   12'd320,  0, '0},
      '{12'd4095, 12'd1,    0, '0},
      '{12'd2048, 12'd600,  0, '0},
      '{12'd2048, 12'd1650, 0, '0},
      '{12'd3,    12'd3299, 0, '0},
      '{12'd5,    12'd3298, 0, '0},
      '{12'd7,    12'd2,    0, '0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (dir_rows[r])
      for (int b = 0; b < GROUP; b++)
        send_beat(dir_rows[r].supply, dir_rows[r].sensor, dir_rows[r].typed,
                  dir_rows[r].want);
    random_groups(10);
    drain();

    // upper extremes, wide band
    s = '{32'd65535, 32'd5000, 32'd1, 32'd1000000, 32'd10000,
          32'hFFFF_EC78, 32'd20000, 32'hFFFF_EC78};
    load_setting(s);
    random_groups(10);
    drain();

    // lower extremes, inverted thresholds
    s = '{32'd0, 32'd1000, 32'd1000000, 32'd1, 32'd1000,
          32'd20000, 32'hFFFF_EC78, 32'd20000};
    load_setting(s);
    no_gaps = 1;
    random_groups(8);
    drain();
    no_gaps = 0;

    // zero resistors and beta, rail at full scale
    s = '{32'h0000_FFFF, 32'h1FFF, 32'd0, 32'd0, 32'd0,
          32'd6000, 32'd7000, 32'd5000};
    load_setting(s);
    random_groups(8);
    drain();

    // back to defaults with the output held off
    s = '{32'd2816, 32'd3300, 32'd10000, 32'd10000, 32'd3950,
          32'd7000, 32'd8500, 32'd6500};
    load_setting(s);
    hold_req = 1;
    random_groups(12);
    drain();

    for (int k = 0; k < 3; k++) begin
      s[0] = $urandom_range(0, 65535);
      s[1] = $urandom_range(1000, 5000);
      s[2] = $urandom_range(1, 1000000);
      s[3] = $urandom_range(1, 1000000);
      s[4] = $urandom_range(1000, 10000);
      s[5] = $urandom_range(0, 65535);
      s[6] = $urandom_range(0, 65535);
      s[7] = $urandom_range(0, 65535);
      if (k == 0) begin
        s[5] = $urandom_range(4000, 8000);
        s[6] = s[5] + $urandom_range(1, 3000);
        s[7] = s[5] - $urandom_range(0, 1000);
      end
      load_setting(s);
      random_groups(6);
      drain();
    end

    $display("%0d beats in, %0d results over 8 register settings", n_beats, n_results);
    $display("%0d sensor-fault and %0d over-temp results seen", n_faults, n_hot);
    if (n_err == 0) begin
      $display("tb_ntc_thermal_derate_monitor OK");
    end else begin
      $display("tb_ntc_thermal_derate_monitor NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ntdm_pkg.sv
hdl/ntdm_fifo.sv
hdl/ntdm_front.sv
hdl/ntdm_div.sv
hdl/ntdm_back.sv
hdl/ntc_thermal_derate_monitor.sv
tb/sv/tb_ntc_thermal_derate_monitor.sv
